FILE: hw/rtl/vdsid_pkg.sv
package vdsid_pkg;

  // Default sizes handed to the top level
  localparam int PHASES_DEF        = 3;
  localparam int VALUE_BITS_DEF    = 16;
  localparam int DURATION_BITS_DEF = 24;

  // Event detectors kept for each phase
  localparam int NUM_KINDS = 3;

  typedef enum logic [1:0] {
    KIND_DIP   = 2'd0,
    KIND_SWELL = 2'd1,
    KIND_INTR  = 2'd2
  } kind_t;

  // Register file: four 32-bit words
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_DIP_THR   = 2'd0;
  localparam logic [1:0] REG_SWELL_THR = 2'd1;
  localparam logic [1:0] REG_INTR_THR  = 2'd2;
  localparam logic [1:0] REG_DECLARED  = 2'd3;

  // Register reset values, converter units
  localparam int DIP_THR_RST   = 20700;
  localparam int SWELL_THR_RST = 25300;
  localparam int INTR_THR_RST  = 1150;
  localparam int DECLARED_RST  = 23000;

  // Hysteresis is 2% of the declared voltage, i.e. declared / 50
  localparam int HYST_DIV   = 50;
  // Extra shift that keeps the reciprocal multiply exact for divisors below 64
  localparam int HYST_EXTRA = 6;

endpackage

FILE: hw/rtl/voltage_dip_swell_interruption_detector_core.sv
// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_stall   phase, rms_value
// out_      result     out_valid/out_stall phase_res, event_kind, ended, extreme_value,
//                                          duration_halfcycles, last
// cfg       APB write  psel/penable/pready four 32-bit registers at byte offsets 0,4,8,12
//
// A request is registered, then evaluated against per-phase detector state;
// its zero to three results go into a three-slot result buffer.
// One result leaves per cycle while the output is not stalled.
// A new request is taken while the buffer still shows the last result of the previous one,
// provided that result is accepted. Reset is synchronous, active low; it clears the detector
// flags and durations. A stalled output holds its result; the input stalls only while a
// request waits in the input register and the buffer still holds results that do not all leave this cycle.
module voltage_dip_swell_interruption_detector_core #(
  parameter int PHASES        = vdsid_pkg::PHASES_DEF,
  parameter int VALUE_BITS    = vdsid_pkg::VALUE_BITS_DEF,
  parameter int DURATION_BITS = vdsid_pkg::DURATION_BITS_DEF,
  localparam int PH_W         = (PHASES > 4) ? $clog2(PHASES) : 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [PH_W-1:0]                      in_phase,
  input  logic [VALUE_BITS-1:0]                in_rms_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [PH_W-1:0]                      out_phase_res,
  output logic [1:0]                           out_event_kind,
  output logic                                 out_ended,
  output logic [VALUE_BITS-1:0]                out_extreme_value,
  output logic [DURATION_BITS-1:0]             out_duration_halfcycles,
  output logic                                 out_last,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vdsid_pkg::ADDR_W-1:0]         paddr,
  input  logic [vdsid_pkg::DATA_W-1:0]         pwdata,
  output logic [vdsid_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int NK         = vdsid_pkg::NUM_KINDS;
  localparam int VX_W       = VALUE_BITS + 1;
  localparam int PROD_W     = 2 * VALUE_BITS + 1;
  localparam int HYST_SHIFT = VALUE_BITS + vdsid_pkg::HYST_EXTRA;
  localparam logic [63:0] HYST_MUL_FULL =
      ((64'd1 << HYST_SHIFT) + 64'(vdsid_pkg::HYST_DIV - 1)) / 64'(vdsid_pkg::HYST_DIV);
  localparam logic [VALUE_BITS:0] HYST_MUL = HYST_MUL_FULL[VALUE_BITS:0];
  localparam logic [VALUE_BITS-1:0] HYST_RST =
      VALUE_BITS'(vdsid_pkg::DECLARED_RST / vdsid_pkg::HYST_DIV);
  localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] dip_thr_r, swell_thr_r, intr_thr_r, decl_r, hyst_r;
  logic [VALUE_BITS-1:0] hyst_nxt;
  logic [PROD_W-1:0]     hyst_prod;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[vdsid_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_thr_r   <= VALUE_BITS'(vdsid_pkg::DIP_THR_RST);
      swell_thr_r <= VALUE_BITS'(vdsid_pkg::SWELL_THR_RST);
      intr_thr_r  <= VALUE_BITS'(vdsid_pkg::INTR_THR_RST);
      decl_r      <= VALUE_BITS'(vdsid_pkg::DECLARED_RST);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        vdsid_pkg::REG_DIP_THR:   dip_thr_r   <= pwdata[VALUE_BITS-1:0];
        vdsid_pkg::REG_SWELL_THR: swell_thr_r <= pwdata[VALUE_BITS-1:0];
        vdsid_pkg::REG_INTR_THR:  intr_thr_r  <= pwdata[VALUE_BITS-1:0];
        vdsid_pkg::REG_DECLARED:  decl_r      <= pwdata[VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_idx)
      vdsid_pkg::REG_DIP_THR:   prdata = vdsid_pkg::DATA_W'(dip_thr_r);
      vdsid_pkg::REG_SWELL_THR: prdata = vdsid_pkg::DATA_W'(swell_thr_r);
      vdsid_pkg::REG_INTR_THR:  prdata = vdsid_pkg::DATA_W'(intr_thr_r);
      vdsid_pkg::REG_DECLARED:  prdata = vdsid_pkg::DATA_W'(decl_r);
      default:                  prdata = '0;
    endcase
  end

  // Hysteresis = declared / 50 via reciprocal multiply, registered
  assign hyst_prod = PROD_W'(decl_r) * PROD_W'(HYST_MUL);
  assign hyst_nxt  = VALUE_BITS'(hyst_prod >> HYST_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r <= HYST_RST;
    end else begin
      hyst_r <= hyst_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                  s1_v_r;
  logic [PH_W-1:0]       s1_phase_r;
  logic [VALUE_BITS-1:0] s1_val_r;
  logic                  s1_go;
  logic                  buf_free;
  logic                  in_fire;
  logic                  out_fire;

  assign in_stall = s1_v_r & ~buf_free;
  assign in_fire  = in_valid & ~in_stall;
  assign s1_go    = s1_v_r & buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!s1_v_r || s1_go) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_phase_r <= in_phase;
      s1_val_r   <= in_rms_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-phase detector state
  // ---------------------------------------------------------------------------
  logic                     act_r [NK][PHASES];
  logic [VALUE_BITS-1:0]    ext_r [NK][PHASES];
  logic [DURATION_BITS-1:0] dur_r [NK][PHASES];

  logic                     phase_ok;
  logic [NK-1:0]            start, stop, fire;
  logic [VALUE_BITS-1:0]    ext_nxt [NK];
  logic [DURATION_BITS-1:0] dur_nxt [NK];
  logic [VX_W-1:0]          vx, hx, dipx, swx, intrx;

  assign phase_ok = ({1'b0, s1_phase_r} < (PH_W + 1)'(PHASES));

  // Start/stop conditions, compared one bit wider so threshold +/- H never wraps
  always_comb begin
    vx    = VX_W'(s1_val_r);
    hx    = VX_W'(hyst_r);
    dipx  = VX_W'(dip_thr_r);
    swx   = VX_W'(swell_thr_r);
    intrx = VX_W'(intr_thr_r);
    start[int'(vdsid_pkg::KIND_DIP)]   = (s1_val_r < dip_thr_r) && (s1_val_r > intr_thr_r);
    stop[int'(vdsid_pkg::KIND_DIP)]    = (vx >= dipx + hx) || (s1_val_r < intr_thr_r);
    start[int'(vdsid_pkg::KIND_SWELL)] = (s1_val_r > swell_thr_r);
    stop[int'(vdsid_pkg::KIND_SWELL)]  = (vx + hx <= swx);
    start[int'(vdsid_pkg::KIND_INTR)]  = (s1_val_r < intr_thr_r);
    stop[int'(vdsid_pkg::KIND_INTR)]   = (vx >= intrx + hx);
  end

  // Extreme and duration update for each detector of the addressed phase
  always_comb begin
    logic                     act_o;
    logic [VALUE_BITS-1:0]    ext_o;
    logic [DURATION_BITS-1:0] dur_o;
    for (int k = 0; k < NK; k++) begin
      act_o = act_r[k][s1_phase_r];
      ext_o = ext_r[k][s1_phase_r];
      dur_o = dur_r[k][s1_phase_r];
      fire[k] = phase_ok & (act_o | start[k]);
      if (!act_o) begin
        // fresh event: extreme is this value, duration restarts
        ext_nxt[k] = s1_val_r;
        dur_nxt[k] = '0;
      end else begin
        if (k == int'(vdsid_pkg::KIND_SWELL)) begin
          ext_nxt[k] = (s1_val_r > ext_o) ? s1_val_r : ext_o;
        end else begin
          ext_nxt[k] = (s1_val_r < ext_o) ? s1_val_r : ext_o;
        end
        dur_nxt[k] = (dur_o == DUR_MAX) ? dur_o : dur_o + 1'b1;
      end
    end
  end

  // Active flags and durations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NK; k++) begin
        for (int p = 0; p < PHASES; p++) begin
          act_r[k][p] <= 1'b0;
          dur_r[k][p] <= '0;
        end
      end
    end else if (s1_go) begin
      for (int k = 0; k < NK; k++) begin
        if (fire[k]) begin
          act_r[k][s1_phase_r] <= ~stop[k];
          dur_r[k][s1_phase_r] <= stop[k] ? '0 : dur_nxt[k];
        end
      end
    end
  end

  // Extremes: written at start and while active, no reset
  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int k = 0; k < NK; k++) begin
        if (fire[k]) begin
          ext_r[k][s1_phase_r] <= ext_nxt[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: one slot per detector, drained lowest kind first
  // ---------------------------------------------------------------------------
  logic [NK-1:0]            res_mask_r;
  logic [PH_W-1:0]          res_phase_r;
  logic [NK-1:0]            res_end_r;
  logic [VALUE_BITS-1:0]    res_ext_r [NK];
  logic [DURATION_BITS-1:0] res_dur_r [NK];
  logic [NK-1:0]            low_bit;
  vdsid_pkg::kind_t         sel;

  assign low_bit  = res_mask_r & (~res_mask_r + 1'b1);
  assign out_fire = out_valid & ~out_stall;
  assign buf_free = (res_mask_r == '0) || (~out_stall && $onehot(res_mask_r));

  always_comb begin
    sel = vdsid_pkg::KIND_DIP;
    for (int k = NK - 1; k >= 0; k--) begin
      if (res_mask_r[k]) begin
        sel = vdsid_pkg::kind_t'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_mask_r <= '0;
    end else if (s1_go) begin
      res_mask_r <= fire;
    end else if (out_fire) begin
      res_mask_r <= res_mask_r & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_phase_r <= s1_phase_r;
      res_end_r   <= stop;
      for (int k = 0; k < NK; k++) begin
        res_ext_r[k] <= ext_nxt[k];
        res_dur_r[k] <= dur_nxt[k];
      end
    end
  end

  // Output drive
  assign out_valid               = |res_mask_r;
  assign out_phase_res           = res_phase_r;
  assign out_event_kind          = sel;
  assign out_ended               = res_end_r[sel];
  assign out_extreme_value       = res_ext_r[sel];
  assign out_duration_halfcycles = res_dur_r[sel];
  assign out_last                = $onehot(res_mask_r);

`ifndef NO_ASSERTIONS
  // Buffer holds its contents while the result is stalled
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && !s1_go |=> $stable(res_mask_r))
    else $error("result buffer changed under stall");

  // An accepted result without a refill removes exactly one slot
  a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !s1_go |=> $countones(res_mask_r) == $countones($past(res_mask_r)) - 1)
    else $error("result drain removed wrong number of slots");

  // Input stalls only when a request is waiting in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && (res_mask_r != '0))
    else $error("input stalled with nothing pending");

  // Buffer is refilled only once the previous request's results are all taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && out_valid |-> out_last && !out_stall)
    else $error("result buffer overwritten before drained");
`endif

endmodule
